FILE: rtl/ppr_pkg.sv
// Shared types, codes and constants for the process priority recompute pipeline.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ppr_pkg;

  // Width of load_average * load_multiplier, also the usage divisor width.
  localparam int unsigned LM_W       = 20;
  // Width of cpu_usage * (load*multiplier) before the Q8 shift.
  localparam int unsigned UPROD_W    = 28;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned PCT_W      = 16;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned PCT_STEPS  = PCT_W / DIV_STAGES;

  localparam logic [15:0] DECAY_Q16     = 16'd62340;
  localparam logic [11:0] DECAY_CMP_Q16 = 12'd3196;
  localparam logic [6:0]  PRI_MAX       = 7'd127;
  localparam logic [7:0]  CPU_MAX       = 8'd255;

  // Process states.
  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_SLEEP   = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_RUN     = 3'd3;
  localparam logic [2:0] ST_CREATE  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE  = 3'd5;
  localparam logic [2:0] ST_STOP    = 3'd6;
  localparam logic [2:0] ST_UNUSED  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LOAD_AVG   = 3'd0;
  localparam logic [2:0] CFG_LOAD_MUL   = 3'd1;
  localparam logic [2:0] CFG_TICKS      = 3'd2;
  localparam logic [2:0] CFG_USER_BASE  = 3'd3;
  localparam logic [2:0] CFG_NICE_ZERO  = 3'd4;
  localparam logic [2:0] CFG_MEM_LOW    = 3'd5;
  localparam logic [2:0] CFG_CUR_PRI    = 3'd6;
  localparam logic [2:0] CFG_NO_RUNNING = 3'd7;

  typedef struct packed {
    logic [15:0] load_average;
    logic [3:0]  load_multiplier;
    logic [9:0]  ticks_per_second;
    logic [6:0]  user_priority_base;
    logic [5:0]  nice_zero;
    logic        memory_low;
    logic [6:0]  current_priority;
    logic        no_process_running;
  } cfg_t;

  // Record as it travels down the pipeline, with the two divider states.
  typedef struct packed {
    logic              live;
    logic [2:0]        proc_state;
    logic              loaded;
    logic              is_current;
    logic [6:0]        run_time;
    logic [6:0]        sleep_time;
    logic [7:0]        cpu_usage;
    logic [5:0]        nice;
    logic [15:0]       pct_cpu;
    logic              mem_over;
    logic [6:0]        priority_req;
    logic [LM_W-1:0]   udiv_rem;
    logic [LM_W-1:0]   udiv_den;
    logic [QUO_W-1:0]  udiv_quo;
    logic [TICK_W-1:0] pdiv_rem;
    logic [TICK_W-1:0] pdiv_den;
    logic [PCT_W-1:0]  pdiv_quo;
    logic              pct_full;
  } item_t;

  function automatic logic [6:0] sat_inc7(input logic [6:0] v);
    sat_inc7 = (v == PRI_MAX) ? v : v + 7'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ppr_cfg_regs.sv
// Configuration register file of the priority recompute block.
// Depends on ppr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ppr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output ppr_pkg::cfg_t      cfg
);

  ppr_pkg::cfg_t cfg_r;
  ppr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ppr_pkg::CFG_LOAD_AVG:   cfg_nxt.load_average       = cfg_data;
        ppr_pkg::CFG_LOAD_MUL:   cfg_nxt.load_multiplier    = cfg_data[3:0];
        ppr_pkg::CFG_TICKS:      cfg_nxt.ticks_per_second   = cfg_data[9:0];
        ppr_pkg::CFG_USER_BASE:  cfg_nxt.user_priority_base = cfg_data[6:0];
        ppr_pkg::CFG_NICE_ZERO:  cfg_nxt.nice_zero          = cfg_data[5:0];
        ppr_pkg::CFG_MEM_LOW:    cfg_nxt.memory_low         = cfg_data[0];
        ppr_pkg::CFG_CUR_PRI:    cfg_nxt.current_priority   = cfg_data[6:0];
        ppr_pkg::CFG_NO_RUNNING: cfg_nxt.no_process_running = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.load_average       <= 16'd256;
      cfg_r.load_multiplier    <= 4'd2;
      cfg_r.ticks_per_second   <= 10'd100;
      cfg_r.user_priority_base <= 7'd50;
      cfg_r.nice_zero          <= 6'd20;
      cfg_r.memory_low         <= 1'b0;
      cfg_r.current_priority   <= 7'd127;
      cfg_r.no_process_running <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/ppr_front.sv
// First two pipeline stages: record decode, counters, load product, usage product.
// Depends on ppr_pkg for item_t, cfg_t, state codes and widths.
`default_nettype none

module ppr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ppr_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_proc_state,
  input  wire logic          in_loaded,
  input  wire logic          in_is_current,
  input  wire logic [6:0]    in_run_time,
  input  wire logic [6:0]    in_sleep_time,
  input  wire logic [7:0]    in_cpu_usage,
  input  wire logic [5:0]    in_nice,
  input  wire logic [9:0]    in_cpu_ticks,
  input  wire logic [15:0]   in_pct_cpu,
  input  wire logic [23:0]   in_resident_size,
  input  wire logic [23:0]   in_max_resident,
  input  wire logic [6:0]    in_priority_req,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output ppr_pkg::item_t     dn_item
);

  logic                           s1_valid_r;
  ppr_pkg::item_t                 s1_item_r;
  ppr_pkg::item_t                 s1_nxt;
  logic                           s2_valid_r;
  ppr_pkg::item_t                 s2_item_r;
  ppr_pkg::item_t                 s2_nxt;
  logic                           s1_ready;
  logic                           s2_ready;
  logic                           live;
  logic                           sleeping;
  logic [ppr_pkg::TICK_W-1:0]     hz_eff;
  logic                           ticks_full;
  logic [ppr_pkg::UPROD_W-1:0]    uprod;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: classify the record, bump counters, form load*multiplier.
  always_comb begin
    case (in_proc_state) inside
      ppr_pkg::ST_EMPTY, ppr_pkg::ST_ZOMBIE, ppr_pkg::ST_UNUSED: live = 1'b0;
      default: live = 1'b1;
    endcase
    case (in_proc_state) inside
      ppr_pkg::ST_SLEEP, ppr_pkg::ST_STOP: sleeping = 1'b1;
      default: sleeping = 1'b0;
    endcase
    hz_eff     = (cfg.ticks_per_second == '0) ? ppr_pkg::TICK_W'(1) : cfg.ticks_per_second;
    ticks_full = (in_cpu_ticks >= hz_eff);

    s1_nxt.live         = live;
    s1_nxt.proc_state   = in_proc_state;
    s1_nxt.loaded       = in_loaded;
    s1_nxt.is_current   = in_is_current;
    s1_nxt.run_time     = live ? ppr_pkg::sat_inc7(in_run_time) : in_run_time;
    s1_nxt.sleep_time   = (live && sleeping) ? ppr_pkg::sat_inc7(in_sleep_time)
                                             : in_sleep_time;
    s1_nxt.cpu_usage    = in_cpu_usage;
    s1_nxt.nice         = in_nice;
    s1_nxt.pct_cpu      = in_pct_cpu;
    s1_nxt.mem_over     = (in_resident_size > in_max_resident);
    s1_nxt.priority_req = in_priority_req;
    s1_nxt.udiv_rem     = '0;
    // Holds load*multiplier until stage 2 turns it into the divisor.
    s1_nxt.udiv_den     = ppr_pkg::LM_W'(cfg.load_average) *
                          ppr_pkg::LM_W'(cfg.load_multiplier);
    s1_nxt.udiv_quo     = '0;
    s1_nxt.pdiv_rem     = ticks_full ? '0 : in_cpu_ticks;
    s1_nxt.pdiv_den     = hz_eff;
    s1_nxt.pdiv_quo     = '0;
    s1_nxt.pct_full     = ticks_full;
  end

  // Stage 2: t = cpu*lm >> 8 becomes the first partial remainder, divisor lm + 256.
  always_comb begin
    uprod             = ppr_pkg::UPROD_W'(s1_item_r.cpu_usage) *
                        ppr_pkg::UPROD_W'(s1_item_r.udiv_den);
    s2_nxt            = s1_item_r;
    s2_nxt.udiv_rem   = uprod[ppr_pkg::UPROD_W-1:8];
    s2_nxt.udiv_den   = s1_item_r.udiv_den + ppr_pkg::LM_W'(256);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item_r <= s1_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_item_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule

`default_nettype wire

FILE: rtl/ppr_div_step.sv
// One divider stage: one quotient bit of the usage decay, two of the tick fraction.
// Depends on ppr_pkg for item_t and widths.
`default_nettype none

module ppr_div_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire ppr_pkg::item_t up_item,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output ppr_pkg::item_t      dn_item
);

  logic                         valid_r;
  ppr_pkg::item_t               item_r;
  ppr_pkg::item_t               item_nxt;
  logic [ppr_pkg::LM_W:0]       urem2;
  logic [ppr_pkg::TICK_W:0]     prem2;

  assign up_ready = !valid_r || dn_ready;

  // The partial remainder always stays below the divisor, so each step is a
  // shift, one compare and a conditional subtract.
  always_comb begin
    item_nxt = up_item;

    urem2 = {up_item.udiv_rem, 1'b0};
    if (urem2 >= {1'b0, up_item.udiv_den}) begin
      urem2 = urem2 - {1'b0, up_item.udiv_den};
      item_nxt.udiv_quo = {up_item.udiv_quo[ppr_pkg::QUO_W-2:0], 1'b1};
    end else begin
      item_nxt.udiv_quo = {up_item.udiv_quo[ppr_pkg::QUO_W-2:0], 1'b0};
    end
    item_nxt.udiv_rem = urem2[ppr_pkg::LM_W-1:0];

    for (int k = 0; k < int'(ppr_pkg::PCT_STEPS); k++) begin
      prem2 = {item_nxt.pdiv_rem, 1'b0};
      if (prem2 >= {1'b0, up_item.pdiv_den}) begin
        prem2 = prem2 - {1'b0, up_item.pdiv_den};
        item_nxt.pdiv_quo = {item_nxt.pdiv_quo[ppr_pkg::PCT_W-2:0], 1'b1};
      end else begin
        item_nxt.pdiv_quo = {item_nxt.pdiv_quo[ppr_pkg::PCT_W-2:0], 1'b0};
      end
      item_nxt.pdiv_rem = prem2[ppr_pkg::TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

FILE: rtl/ppr_back.sv
// Last two stages: decay products and usage clamp, then priority and output register.
// Depends on ppr_pkg for item_t, cfg_t, state codes and constants.
`default_nettype none

module ppr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ppr_pkg::cfg_t  cfg,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire ppr_pkg::item_t up_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_active,
  output logic [6:0]          out_new_run_time,
  output logic [6:0]          out_new_sleep_time,
  output logic [7:0]          out_new_cpu_usage,
  output logic [15:0]         out_new_pct_cpu,
  output logic [6:0]          out_user_priority,
  output logic [6:0]          out_new_priority,
  output logic                out_requeue,
  output logic                out_reschedule
);

  // Stage A registers.
  logic               a_valid_r;
  ppr_pkg::item_t     a_item_r;
  logic [7:0]         a_cpu_r;
  logic signed [6:0]  a_nz_r;
  logic [31:0]        a_prod_pct_r;
  logic [28:0]        a_prod_f_r;
  logic [7:0]         a_cpu_nxt;
  logic signed [6:0]  a_nz_nxt;
  logic [31:0]        a_prod_pct_nxt;
  logic [28:0]        a_prod_f_nxt;
  logic [16:0]        frac;
  logic signed [9:0]  usage_sum;

  // Output register.
  logic               o_valid_r;
  logic               o_active_r;
  logic [6:0]         o_run_r;
  logic [6:0]         o_sleep_r;
  logic [7:0]         o_cpu_r;
  logic [15:0]        o_pct_r;
  logic [6:0]         o_usr_r;
  logic [6:0]         o_npri_r;
  logic               o_rq_r;
  logic               o_resched_r;
  logic [7:0]         o_cpu_nxt;
  logic [15:0]        o_pct_nxt;
  logic [6:0]         o_usr_nxt;
  logic [6:0]         o_npri_nxt;
  logic               o_rq_nxt;
  logic               o_resched_nxt;
  logic [32:0]        pct_sum;
  logic [15:0]        pct_dec;
  logic signed [9:0]  pri_sum;
  logic [6:0]         usr;

  logic               a_ready;
  logic               o_ready;

  assign o_ready  = !o_valid_r || out_ready;
  assign a_ready  = !a_valid_r || o_ready;
  assign up_ready = a_ready;

  // Stage A: the two decay products and the clamped usage.
  always_comb begin
    frac           = up_item.pct_full ? 17'h10000 : {1'b0, up_item.pdiv_quo};
    a_prod_pct_nxt = {16'd0, ppr_pkg::DECAY_Q16} * {16'd0, up_item.pct_cpu};
    a_prod_f_nxt   = {17'd0, ppr_pkg::DECAY_CMP_Q16} * {12'd0, frac};
    a_nz_nxt       = $signed({1'b0, up_item.nice}) - $signed({1'b0, cfg.nice_zero});
    usage_sum      = $signed({2'b00, up_item.udiv_quo}) +
                     $signed({{3{a_nz_nxt[6]}}, a_nz_nxt});
    if (usage_sum < 10'sd0) begin
      a_cpu_nxt = '0;
    end else if (usage_sum > 10'sd255) begin
      a_cpu_nxt = ppr_pkg::CPU_MAX;
    end else begin
      a_cpu_nxt = usage_sum[7:0];
    end
  end

  // Stage B: rounded percent, user priority, queue and reschedule flags.
  always_comb begin
    pct_sum = {1'b0, a_prod_pct_r} + {4'd0, a_prod_f_r} + 33'd32768;
    pct_dec = pct_sum[32] ? 16'hFFFF : pct_sum[31:16];

    pri_sum = $signed({4'd0, a_cpu_r[7:2]}) +
              $signed({3'd0, cfg.user_priority_base}) +
              $signed({{2{a_nz_r[6]}}, a_nz_r, 1'b0}) +
              ((a_item_r.mem_over && cfg.memory_low) ? 10'sd8 : 10'sd0);
    if (pri_sum < 10'sd0) begin
      usr = '0;
    end else if (pri_sum > 10'sd127) begin
      usr = ppr_pkg::PRI_MAX;
    end else begin
      usr = pri_sum[6:0];
    end

    o_cpu_nxt     = a_cpu_r;
    o_pct_nxt     = a_item_r.loaded ? pct_dec : a_item_r.pct_cpu;
    o_usr_nxt     = usr;
    o_resched_nxt = (usr < cfg.current_priority);
    o_npri_nxt    = a_item_r.priority_req;
    o_rq_nxt      = 1'b0;
    if (a_item_r.priority_req >= cfg.user_priority_base) begin
      o_npri_nxt = usr;
      o_rq_nxt   = (!a_item_r.is_current || cfg.no_process_running) &&
                   (a_item_r.proc_state == ppr_pkg::ST_RUN) &&
                   a_item_r.loaded && (a_item_r.priority_req != usr);
    end

    // Empty, zombie and unused records leave unchanged, with the derived flags cleared.
    if (!a_item_r.live) begin
      o_cpu_nxt     = a_item_r.cpu_usage;
      o_pct_nxt     = a_item_r.pct_cpu;
      o_usr_nxt     = '0;
      o_resched_nxt = 1'b0;
      o_npri_nxt    = a_item_r.priority_req;
      o_rq_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (o_ready) begin
        o_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item_r     <= up_item;
      a_cpu_r      <= a_cpu_nxt;
      a_nz_r       <= a_nz_nxt;
      a_prod_pct_r <= a_prod_pct_nxt;
      a_prod_f_r   <= a_prod_f_nxt;
    end
    if (o_ready && a_valid_r) begin
      o_active_r  <= a_item_r.live;
      o_run_r     <= a_item_r.run_time;
      o_sleep_r   <= a_item_r.sleep_time;
      o_cpu_r     <= o_cpu_nxt;
      o_pct_r     <= o_pct_nxt;
      o_usr_r     <= o_usr_nxt;
      o_npri_r    <= o_npri_nxt;
      o_rq_r      <= o_rq_nxt;
      o_resched_r <= o_resched_nxt;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_active         = o_active_r;
  assign out_new_run_time   = o_run_r;
  assign out_new_sleep_time = o_sleep_r;
  assign out_new_cpu_usage  = o_cpu_r;
  assign out_new_pct_cpu    = o_pct_r;
  assign out_user_priority  = o_usr_r;
  assign out_new_priority   = o_npri_r;
  assign out_requeue        = o_rq_r;
  assign out_reschedule     = o_resched_r;

endmodule

`default_nettype wire

FILE: rtl/process_priority_recompute.sv
// Top level of the once-per-second process priority recompute pipeline.
// Depends on ppr_pkg, ppr_cfg_regs, ppr_front, ppr_div_step and ppr_back.
//
//   Port group  Direction  Handshake          Carries
//   in_*        input      in_valid/in_ready  one process record per beat
//   out_*       output     out_valid/out_ready one recomputed record per beat
//   cfg_*       input      cfg_we, no wait    register index and write data
//
// Every record passes twelve register stages: two front stages, eight divider
// stages and two back stages. One record enters per cycle while the output
// side is not stalled. The depth is set mostly by the eight-stage divider,
// which yields one bit of the usage quotient and two bits of the tick
// fraction per stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. Each stage holds its beat while the stage after it is
// full, so a stalled output only backs up as far as the first empty stage.
`default_nettype none

module process_priority_recompute (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // Configuration writes.
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  // Record input.
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_proc_state,
  input  wire logic          in_loaded,
  input  wire logic          in_is_current,
  input  wire logic [6:0]    in_run_time,
  input  wire logic [6:0]    in_sleep_time,
  input  wire logic [7:0]    in_cpu_usage,
  input  wire logic [5:0]    in_nice,
  input  wire logic [9:0]    in_cpu_ticks,
  input  wire logic [15:0]   in_pct_cpu,
  input  wire logic [23:0]   in_resident_size,
  input  wire logic [23:0]   in_max_resident,
  input  wire logic [6:0]    in_priority_req,
  // Result output.
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_active,
  output logic [6:0]         out_new_run_time,
  output logic [6:0]         out_new_sleep_time,
  output logic [7:0]         out_new_cpu_usage,
  output logic [15:0]        out_new_pct_cpu,
  output logic [6:0]         out_user_priority,
  output logic [6:0]         out_new_priority,
  output logic               out_requeue,
  output logic               out_reschedule
);

  ppr_pkg::cfg_t                        cfg;
  logic [ppr_pkg::DIV_STAGES:0]         chain_valid;
  logic [ppr_pkg::DIV_STAGES:0]         chain_ready;
  ppr_pkg::item_t                       chain_item [ppr_pkg::DIV_STAGES+1];

  // Registers feed front and back directly; user writes must only happen while
  // the pipeline is empty, so no record sees a mix of settings (not enforced).
  ppr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Decode, saturating counters, load product and the usage product.
  ppr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_proc_state    (in_proc_state),
    .in_loaded        (in_loaded),
    .in_is_current    (in_is_current),
    .in_run_time      (in_run_time),
    .in_sleep_time    (in_sleep_time),
    .in_cpu_usage     (in_cpu_usage),
    .in_nice          (in_nice),
    .in_cpu_ticks     (in_cpu_ticks),
    .in_pct_cpu       (in_pct_cpu),
    .in_resident_size (in_resident_size),
    .in_max_resident  (in_max_resident),
    .in_priority_req  (in_priority_req),
    .dn_valid         (chain_valid[0]),
    .dn_ready         (chain_ready[0]),
    .dn_item          (chain_item[0])
  );

  // Two restoring dividers share the chain: the usage decay
  // (t*256)/(lm+256), whose quotient is known to fit eight bits, and the
  // tick fraction (ticks*65536)/hz, sixteen bits unless ticks reach hz.
  for (genvar g = 0; g < int'(ppr_pkg::DIV_STAGES); g++) begin : g_div
    ppr_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_item  (chain_item[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_item  (chain_item[g+1])
    );
  end

  // Percent decay with round half up, clamped usage, user priority, flags.
  ppr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .up_valid           (chain_valid[ppr_pkg::DIV_STAGES]),
    .up_ready           (chain_ready[ppr_pkg::DIV_STAGES]),
    .up_item            (chain_item[ppr_pkg::DIV_STAGES]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_active         (out_active),
    .out_new_run_time   (out_new_run_time),
    .out_new_sleep_time (out_new_sleep_time),
    .out_new_cpu_usage  (out_new_cpu_usage),
    .out_new_pct_cpu    (out_new_pct_cpu),
    .out_user_priority  (out_user_priority),
    .out_new_priority   (out_new_priority),
    .out_requeue        (out_requeue),
    .out_reschedule     (out_reschedule)
  );

  // The input can only be held off when every stage is full and the
  // output beat is waiting.
  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output side could move");

  // Passed-through records carry no derived priority or flags.
  a_passthrough_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active) |->
      (out_user_priority == '0 && !out_requeue && !out_reschedule))
    else $error("inactive record carries derived fields");

  // A run-queue move only happens for a live record that took its new priority.
  a_requeue_priority: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_requeue) |->
      (out_active && out_new_priority == out_user_priority))
    else $error("requeue without a matching new priority");

  // A live record never leaves its resident-seconds counter at zero.
  a_run_time_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_active) |-> (out_new_run_time != '0))
    else $error("live record left run time at zero");

endmodule

`default_nettype wire

FILE: tb/tb_process_priority_recompute.sv
// Self-checking testbench for process_priority_recompute: random and directed process records.
// Depends on ppr_pkg and the RTL top level; expected results come from a predictor kept here.
`default_nettype none

module tb_process_priority_recompute;

  // One process record as it is offered on the input channel.
  typedef struct packed {
    logic [2:0]  proc_state;
    logic        loaded;
    logic        is_current;
    logic [6:0]  run_time;
    logic [6:0]  sleep_time;
    logic [7:0]  cpu_usage;
    logic [5:0]  nice;
    logic [9:0]  cpu_ticks;
    logic [15:0] pct_cpu;
    logic [23:0] resident_size;
    logic [23:0] max_resident;
    logic [6:0]  priority_req;
  } proc_rec_t;

  // One recomputed record as it should leave the output channel.
  typedef struct packed {
    logic        active;
    logic [6:0]  run_time;
    logic [6:0]  sleep_time;
    logic [7:0]  cpu_usage;
    logic [15:0] pct_cpu;
    logic [6:0]  user_pri;
    logic [6:0]  new_pri;
    logic        requeue;
    logic        resched;
  } recompute_t;

  localparam int QUIET_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = ppr_pkg::CFG_LOAD_AVG;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_proc_state = ppr_pkg::ST_EMPTY;
  logic        in_loaded = 1'b0;
  logic        in_is_current = 1'b0;
  logic [6:0]  in_run_time = 7'd0;
  logic [6:0]  in_sleep_time = 7'd0;
  logic [7:0]  in_cpu_usage = 8'd0;
  logic [5:0]  in_nice = 6'd0;
  logic [9:0]  in_cpu_ticks = 10'd0;
  logic [15:0] in_pct_cpu = 16'd0;
  logic [23:0] in_resident_size = 24'd0;
  logic [23:0] in_max_resident = 24'd0;
  logic [6:0]  in_priority_req = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_active;
  logic [6:0]  out_new_run_time;
  logic [6:0]  out_new_sleep_time;
  logic [7:0]  out_new_cpu_usage;
  logic [15:0] out_new_pct_cpu;
  logic [6:0]  out_user_priority;
  logic [6:0]  out_new_priority;
  logic        out_requeue;
  logic        out_reschedule;

  // Records waiting for the driver, and the results owed by the block in order.
  proc_rec_t  records_to_send[$];
  recompute_t owed_results[$];
  // Copy of the record that is on the input ports right now.
  proc_rec_t  sent_rec;
  // The testbench's own view of the configuration registers.
  ppr_pkg::cfg_t sched_cfg;
  // Percent chance that either side idles in a given cycle.
  int         idle_pct = 27;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  process_priority_recompute dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_proc_state      (in_proc_state),
    .in_loaded          (in_loaded),
    .in_is_current      (in_is_current),
    .in_run_time        (in_run_time),
    .in_sleep_time      (in_sleep_time),
    .in_cpu_usage       (in_cpu_usage),
    .in_nice            (in_nice),
    .in_cpu_ticks       (in_cpu_ticks),
    .in_pct_cpu         (in_pct_cpu),
    .in_resident_size   (in_resident_size),
    .in_max_resident    (in_max_resident),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_active         (out_active),
    .out_new_run_time   (out_new_run_time),
    .out_new_sleep_time (out_new_sleep_time),
    .out_new_cpu_usage  (out_new_cpu_usage),
    .out_new_pct_cpu    (out_new_pct_cpu),
    .out_user_priority  (out_user_priority),
    .out_new_priority   (out_new_priority),
    .out_requeue        (out_requeue),
    .out_reschedule     (out_reschedule)
  );

  always #10 clk = ~clk;

  // Predicts what the block makes of one record under the current settings.
  // Empty, zombie and the unused state code pass straight through; everything
  // else gets the counter, usage, percent-cpu and priority updates.
  function automatic recompute_t recompute_priority(input proc_rec_t r);
    recompute_t        e;
    longint unsigned   lm;
    longint unsigned   held;
    longint unsigned   decayed;
    longint unsigned   hz;
    longint unsigned   ticks;
    longint unsigned   frac;
    longint unsigned   mix;
    int                usage;
    int                upri;
    e.active     = 1'b0;
    e.run_time   = r.run_time;
    e.sleep_time = r.sleep_time;
    e.cpu_usage  = r.cpu_usage;
    e.pct_cpu    = r.pct_cpu;
    e.user_pri   = 7'd0;
    e.new_pri    = r.priority_req;
    e.requeue    = 1'b0;
    e.resched    = 1'b0;
    if (r.proc_state == ppr_pkg::ST_EMPTY || r.proc_state == ppr_pkg::ST_ZOMBIE ||
        r.proc_state == ppr_pkg::ST_UNUSED) begin
      return e;
    end
    e.active   = 1'b1;
    e.run_time = (r.run_time == ppr_pkg::PRI_MAX) ? ppr_pkg::PRI_MAX : r.run_time + 7'd1;
    if (r.proc_state == ppr_pkg::ST_SLEEP || r.proc_state == ppr_pkg::ST_STOP) begin
      e.sleep_time = (r.sleep_time == ppr_pkg::PRI_MAX) ? ppr_pkg::PRI_MAX
                                                        : r.sleep_time + 7'd1;
    end
    // Percent-cpu only moves for a resident process. A zero tick rate counts
    // as one tick per second, and ticks beyond the rate are clipped to it.
    if (r.loaded) begin
      hz    = (sched_cfg.ticks_per_second == 10'd0) ? 64'd1
                                                    : 64'(sched_cfg.ticks_per_second);
      ticks = 64'(r.cpu_ticks);
      if (ticks > hz) begin
        ticks = hz;
      end
      frac = (ticks << 16) / hz;
      mix  = 64'(ppr_pkg::DECAY_Q16) * 64'(r.pct_cpu) +
             64'(ppr_pkg::DECAY_CMP_Q16) * frac + 64'd32768;
      mix  = mix >> 16;
      e.pct_cpu = (mix > 64'd65535) ? 16'hFFFF : mix[15:0];
    end
    // Usage decay: both the Q8 product and the quotient are truncated.
    lm      = 64'(sched_cfg.load_average);
    lm      = lm * 64'(sched_cfg.load_multiplier);
    held    = 64'(r.cpu_usage);
    held    = (held * lm) >> 8;
    decayed = (held << 8) / (lm + 64'd256);
    usage   = int'(decayed) + int'(r.nice) - int'(sched_cfg.nice_zero);
    if (usage < 0) usage = 0;
    if (usage > 255) usage = 255;
    e.cpu_usage = usage[7:0];
    upri = usage / 4 + int'(sched_cfg.user_priority_base)
           + 2 * (int'(r.nice) - int'(sched_cfg.nice_zero));
    if (r.resident_size > r.max_resident && sched_cfg.memory_low) begin
      upri = upri + 8;
    end
    if (upri < 0) upri = 0;
    if (upri > 127) upri = 127;
    e.user_pri = upri[6:0];
    e.resched  = (e.user_pri < sched_cfg.current_priority);
    if (r.priority_req >= sched_cfg.user_priority_base) begin
      e.new_pri = e.user_pri;
      e.requeue = (!r.is_current || sched_cfg.no_process_running) &&
                  r.proc_state == ppr_pkg::ST_RUN &&
                  r.loaded && r.priority_req != e.user_pri;
    end
    return e;
  endfunction

  // A random record, biased toward the corners that matter: saturating
  // counters, nice around its neutral value, ticks on both sides of the rate,
  // and a requested priority near the user base or equal to the new one.
  function automatic proc_rec_t make_record();
    proc_rec_t  r;
    recompute_t guess;
    int         tmp;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 5))
        0: r.proc_state = ppr_pkg::ST_SLEEP;
        1: r.proc_state = ppr_pkg::ST_WAIT;
        2: r.proc_state = ppr_pkg::ST_CREATE;
        3: r.proc_state = ppr_pkg::ST_STOP;
        default: r.proc_state = ppr_pkg::ST_RUN;
      endcase
    end else begin
      r.proc_state = 3'($urandom_range(0, 7));
    end
    r.loaded     = ($urandom_range(0, 99) < 80);
    r.is_current = 1'($urandom_range(0, 1));
    r.run_time   = 7'(($urandom_range(0, 9) < 3) ? $urandom_range(125, 127)
                                                 : $urandom_range(0, 127));
    r.sleep_time = 7'(($urandom_range(0, 9) < 3) ? $urandom_range(125, 127)
                                                 : $urandom_range(0, 127));
    r.cpu_usage  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) begin
      tmp = int'(sched_cfg.nice_zero) + int'($urandom_range(0, 16)) - 8;
      r.nice = (tmp < 0) ? 6'd0 : (tmp > 63) ? 6'd63 : tmp[5:0];
    end else begin
      r.nice = 6'($urandom_range(0, 63));
    end
    r.cpu_ticks = 10'($urandom_range(0, 1) ? $urandom_range(0, sched_cfg.ticks_per_second)
                                           : $urandom_range(0, 1023));
    r.pct_cpu       = 16'($urandom_range(0, 65535));
    r.resident_size = 24'($urandom_range(0, 24'hFFFFFF));
    r.max_resident  = 24'(($urandom_range(0, 4) == 0) ? 32'(r.resident_size)
                                                      : $urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 1)) begin
      tmp = int'(sched_cfg.user_priority_base) + int'($urandom_range(0, 4)) - 2;
      r.priority_req = (tmp < 0) ? 7'd0 : (tmp > 127) ? 7'd127 : tmp[6:0];
    end else begin
      r.priority_req = 7'($urandom_range(0, 127));
    end
    // Now and then ask for exactly the priority the block will compute, so
    // that a runnable record can stay where it is.
    if ($urandom_range(0, 9) == 0) begin
      guess = recompute_priority(r);
      r.priority_req = guess.user_pri;
    end
    return r;
  endfunction

  // A quiet, ordinary runnable record that directed cases start from.
  function automatic proc_rec_t plain_record();
    proc_rec_t r;
    r = '0;
    r.proc_state    = ppr_pkg::ST_RUN;
    r.loaded        = 1'b1;
    r.run_time      = 7'd10;
    r.sleep_time    = 7'd3;
    r.cpu_usage     = 8'd100;
    r.nice          = 6'd20;
    r.cpu_ticks     = 10'd40;
    r.pct_cpu       = 16'd12000;
    r.resident_size = 24'd500;
    r.max_resident  = 24'd1000;
    r.priority_req  = 7'd60;
    return r;
  endfunction

  task automatic load_reset_values();
    sched_cfg.load_average       = 16'd256;
    sched_cfg.load_multiplier    = 4'd2;
    sched_cfg.ticks_per_second   = 10'd100;
    sched_cfg.user_priority_base = 7'd50;
    sched_cfg.nice_zero          = 6'd20;
    sched_cfg.memory_low         = 1'b0;
    sched_cfg.current_priority   = 7'd127;
    sched_cfg.no_process_running = 1'b0;
  endtask

  // One register write per clock. The local copy keeps only the bits the
  // register holds, the same truncation the block applies.
  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      ppr_pkg::CFG_LOAD_AVG:   sched_cfg.load_average       = val;
      ppr_pkg::CFG_LOAD_MUL:   sched_cfg.load_multiplier    = val[3:0];
      ppr_pkg::CFG_TICKS:      sched_cfg.ticks_per_second   = val[9:0];
      ppr_pkg::CFG_USER_BASE:  sched_cfg.user_priority_base = val[6:0];
      ppr_pkg::CFG_NICE_ZERO:  sched_cfg.nice_zero          = val[5:0];
      ppr_pkg::CFG_MEM_LOW:    sched_cfg.memory_low         = val[0];
      ppr_pkg::CFG_CUR_PRI:    sched_cfg.current_priority   = val[6:0];
      ppr_pkg::CFG_NO_RUNNING: sched_cfg.no_process_running = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] la, input logic [15:0] lm,
                                input logic [15:0] hz, input logic [15:0] base,
                                input logic [15:0] zero, input logic [15:0] mem,
                                input logic [15:0] cur, input logic [15:0] norun);
    set_reg(ppr_pkg::CFG_LOAD_AVG, la);
    set_reg(ppr_pkg::CFG_LOAD_MUL, lm);
    set_reg(ppr_pkg::CFG_TICKS, hz);
    set_reg(ppr_pkg::CFG_USER_BASE, base);
    set_reg(ppr_pkg::CFG_NICE_ZERO, zero);
    set_reg(ppr_pkg::CFG_MEM_LOW, mem);
    set_reg(ppr_pkg::CFG_CUR_PRI, cur);
    set_reg(ppr_pkg::CFG_NO_RUNNING, norun);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued record has gone in and every owed result has
  // come out, then lets the pipeline run dry before anything else happens.
  // The check sits on the falling edge, where the driver and the monitor
  // have both settled.
  task automatic drain();
    @(negedge clk);
    while (records_to_send.size() != 0 || in_valid || owed_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) records_to_send.push_back(make_record());
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Input driver. A beat moves when in_valid and in_ready are both high at
  // the edge; only then, or while the channel is empty, may a new record be
  // put on the ports. The prediction is made from the record that was on the
  // ports at the accepting edge.
  always @(posedge clk) begin : drive_records
    proc_rec_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_results.push_back(recompute_priority(sent_rec));
      end
      if (!in_valid || in_ready) begin
        if (records_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = records_to_send.pop_front();
          sent_rec         <= nxt;
          in_proc_state    <= nxt.proc_state;
          in_loaded        <= nxt.loaded;
          in_is_current    <= nxt.is_current;
          in_run_time      <= nxt.run_time;
          in_sleep_time    <= nxt.sleep_time;
          in_cpu_usage     <= nxt.cpu_usage;
          in_nice          <= nxt.nice;
          in_cpu_ticks     <= nxt.cpu_ticks;
          in_pct_cpu       <= nxt.pct_cpu;
          in_resident_size <= nxt.resident_size;
          in_max_resident  <= nxt.max_resident;
          in_priority_req  <= nxt.priority_req;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. out_ready is thrown at random every cycle; each accepted
  // beat is checked field by field against the oldest owed result.
  always @(posedge clk) begin : check_results
    recompute_t want;
    out_ready <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual active=%0d",
                 $time, out_active);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        check_field("active", 32'(want.active), 32'(out_active));
        check_field("new_run_time", 32'(want.run_time), 32'(out_new_run_time));
        check_field("new_sleep_time", 32'(want.sleep_time), 32'(out_new_sleep_time));
        check_field("new_cpu_usage", 32'(want.cpu_usage), 32'(out_new_cpu_usage));
        check_field("new_pct_cpu", 32'(want.pct_cpu), 32'(out_new_pct_cpu));
        check_field("user_priority", 32'(want.user_pri), 32'(out_user_priority));
        check_field("new_priority", 32'(want.new_pri), 32'(out_new_priority));
        check_field("requeue", 32'(want.requeue), 32'(out_requeue));
        check_field("reschedule", 32'(want.resched), 32'(out_reschedule));
      end
    end
  end

  // Watchdog: a run that stops moving beats on both channels is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_test
    proc_rec_t  r;
    recompute_t probe;
    int         st;
    load_reset_values();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed records under the reset settings. Every state code, the empty
    // and the all-ones record, ticks at, above and far above the rate, and
    // the corners of the requested priority against the user base.
    for (st = 0; st < 8; st++) begin
      r = plain_record();
      r.proc_state = 3'(st);
      records_to_send.push_back(r);
    end
    r = '0;
    r.proc_state = ppr_pkg::ST_RUN;
    records_to_send.push_back(r);
    r = '1;
    r.proc_state = ppr_pkg::ST_STOP;
    records_to_send.push_back(r);
    r = '1;
    r.proc_state = ppr_pkg::ST_SLEEP;
    r.nice = 6'd0;
    r.priority_req = 7'd0;
    records_to_send.push_back(r);
    r = plain_record();
    r.cpu_ticks = 10'd100;
    records_to_send.push_back(r);
    r = plain_record();
    r.cpu_ticks = 10'd101;
    records_to_send.push_back(r);
    r = plain_record();
    r.cpu_ticks = 10'd1023;
    r.pct_cpu = 16'hFFFF;
    records_to_send.push_back(r);
    r = plain_record();
    r.loaded = 1'b0;
    records_to_send.push_back(r);
    r = plain_record();
    r.is_current = 1'b1;
    records_to_send.push_back(r);
    r = plain_record();
    r.priority_req = 7'd49;
    records_to_send.push_back(r);
    r = plain_record();
    r.priority_req = 7'd50;
    records_to_send.push_back(r);
    r = plain_record();
    probe = recompute_priority(r);
    r.priority_req = probe.user_pri;
    records_to_send.push_back(r);
    r = plain_record();
    r.resident_size = 24'hFFFFFF;
    r.max_resident = 24'd0;
    records_to_send.push_back(r);
    r = plain_record();
    r.nice = 6'd63;
    r.cpu_usage = 8'd255;
    records_to_send.push_back(r);
    r = plain_record();
    r.run_time = 7'd126;
    r.sleep_time = 7'd126;
    r.proc_state = ppr_pkg::ST_SLEEP;
    records_to_send.push_back(r);
    queue_random(150);
    drain();

    // Every register at its top value; writing all ones also checks that
    // the narrow registers keep only their own bits.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(150);
    drain();

    // Every register at zero, including the tick rate that counts as one.
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_random(150);
    drain();

    // A long stretch with no idling on either side, back to back beats.
    idle_pct = 0;
    apply_settings(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 15)),
                   16'($urandom_range(1, 1023)), 16'($urandom_range(0, 127)),
                   16'($urandom_range(0, 63)), 16'd1,
                   16'($urandom_range(0, 127)), 16'd0);
    queue_random(300);
    drain();
    idle_pct = 27;

    // Random settings, a phase at a time.
    repeat (5) begin
      apply_settings(16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 1023)),
                     16'($urandom_range(0, 15)),
                     16'($urandom_range(0, 3) == 0 ? $urandom_range(1, 1023)
                                                   : $urandom_range(1, 200)),
                     16'($urandom_range(0, 127)), 16'($urandom_range(0, 63)),
                     16'($urandom_range(0, 1)),
                     16'($urandom_range(0, 127)), 16'($urandom_range(0, 1)));
      queue_random(190);
      drain();
    end

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/ppr_pkg.sv
rtl/ppr_cfg_regs.sv
rtl/ppr_front.sv
rtl/ppr_div_step.sv
rtl/ppr_back.sv
rtl/process_priority_recompute.sv
tb/tb_process_priority_recompute.sv
